// File: hdl/tkns_pkg.sv
// ----------------------------------------------------------------------------
// tkns_pkg
// shared constants and types for the top-k nearest selector
// ----------------------------------------------------------------------------
package tkns_pkg;

    localparam int K_MAX       = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int DIST_W      = 32;
    localparam int KEEP_W      = 5;
    // fill count holds 0..K_MAX
    localparam int FILL_W      = $clog2(K_MAX + 1);
    // width for comparing the fill count against the keep count
    localparam int CMP_W       = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic [DIST_W-1:0]      dist_code;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;     // place the candidate, cells behind it move right
        logic shift_out;  // readout, every cell takes its right neighbor
    } cell_ctl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } tkns_state_t;

endpackage

// File: hdl/top_k_nearest_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_nearest_selector_unit
// keeps the k closest of a candidate stream and reads them out sorted
// ----------------------------------------------------------------------------
// Candidates are taken one word per cycle while collecting: each one is
// compared against every slot of a chain of K_MAX cells in the same cycle,
// and the chain shifts right behind its insertion point, so the store is
// always sorted by ascending distance (equal distances in arrival order).
// Until k entries are held every candidate is kept; after that a candidate
// only gets in when strictly closer than the current worst, which then
// falls off the end of the chain. A word with is_final set is offered like
// any other, then the unit drains: the chain shifts left one cell per cycle
// into the output register whenever it is free, so that sink stalls hold
// the drain back; each entry held gives one result word. No candidate
// is accepted during the drain. keep_count is sampled on every offer; 0
// acts as 1 and values above K_MAX act as K_MAX. Lowering it in the middle
// of a query drops nothing already held.
// ----------------------------------------------------------------------------
module top_k_nearest_selector_unit import tkns_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_wdata,
    // candidate words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_cand_index,
    input  logic [DIST_W-1:0] s_cand_dist,
    input  logic              s_is_final,
    // neighbor words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_near_index,
    output logic [DIST_W-1:0] m_near_dist,
    output logic [3:0]        m_near_rank,
    output logic              m_run_end
);

    // configuration register
    logic [KEEP_W-1:0] keep_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_W'(1);
        end else if (cfg_we) begin
            keep_count_reg <= cfg_wdata;
        end
    end

    // effective k, clamped to 1..K_MAX
    logic [CMP_W-1:0] keep_ext;
    logic [CMP_W-1:0] eff_k;

    always_comb begin
        keep_ext = CMP_W'(keep_count_reg);
        if (keep_ext == CMP_W'(0)) begin
            eff_k = CMP_W'(1);
        end else if (keep_ext > CMP_W'(K_MAX)) begin
            eff_k = CMP_W'(K_MAX);
        end else begin
            eff_k = keep_ext;
        end
    end

    // control state
    tkns_state_t       state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] rank_reg, rank_next;

    // output register
    logic   m_valid_reg, m_valid_next;
    entry_t m_entry_reg, m_entry_next;
    logic [FILL_W-1:0] m_rank_reg, m_rank_next;
    logic   m_end_reg, m_end_next;

    // chain wiring
    entry_t       cand;
    entry_t       cell_entry [K_MAX];
    logic [K_MAX-1:0] after_vec;
    logic [K_MAX-1:0] worse_vec;
    logic [K_MAX-1:0] occ_vec;
    cell_ctl_t    ctl;

    logic take;
    logic below_k;
    logic replace_ok;
    logic out_free;
    logic drain_step;

    assign cand.index     = INDEX_WIDTH'(s_cand_index);
    assign cand.dist_code = s_cand_dist;

    assign take       = s_valid && s_ready;
    assign below_k    = CMP_W'(fill_reg) < eff_k;
    // sorted chain: any occupied slot farther means the worst one is farther
    assign replace_ok = |worse_vec;
    assign out_free   = !m_valid_reg || m_ready;

    // handshake and chain commands
    always_comb begin
        s_ready       = 1'b0;
        drain_step    = 1'b0;
        ctl.insert    = 1'b0;
        ctl.shift_out = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_ready    = 1'b1;
                ctl.insert = take && (below_k || replace_ok);
            end
            ST_DRAIN: begin
                drain_step    = out_free;
                ctl.shift_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // next state and counters
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        rank_next  = rank_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (take && below_k) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                if (take && s_is_final) begin
                    state_next = ST_DRAIN;
                    rank_next  = '0;
                end
            end
            ST_DRAIN: begin
                if (drain_step) begin
                    fill_next = fill_reg - FILL_W'(1);
                    rank_next = rank_reg + FILL_W'(1);
                    if (fill_reg == FILL_W'(1)) begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // output register, loaded from the head of the chain
    always_comb begin
        m_valid_next = m_valid_reg;
        m_entry_next = m_entry_reg;
        m_rank_next  = m_rank_reg;
        m_end_next   = m_end_reg;
        if (drain_step) begin
            m_valid_next = 1'b1;
            m_entry_next = cell_entry[0];
            m_rank_next  = rank_reg;
            m_end_next   = (fill_reg == FILL_W'(1));
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            fill_reg    <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_entry_reg <= m_entry_next;
        m_rank_reg  <= m_rank_next;
        m_end_reg   <= m_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_near_index = 16'(m_entry_reg.index);
    assign m_near_dist  = m_entry_reg.dist_code;
    assign m_near_rank  = 4'(m_rank_reg);
    assign m_run_end    = m_end_reg;

    // the chain of cells, slot 0 nearest
    for (genvar i = 0; i < K_MAX; i++) begin : g_cell
        logic   left_after;
        entry_t left_entry;
        entry_t right_entry;

        assign occ_vec[i] = FILL_W'(i) < fill_reg;

        if (i == 0) begin : g_head
            assign left_after = 1'b0;
            assign left_entry = cand;
        end else begin : g_body
            assign left_after = after_vec[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == K_MAX - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        tkns_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occ_vec[i]),
            .cand        (cand),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .after       (after_vec[i]),
            .worse       (worse_vec[i])
        );
    end

endmodule

// File: hdl/tkns_cell.sv
// ----------------------------------------------------------------------------
// tkns_cell
// one slot of the sorted chain: holds an entry, compares it with the
// candidate and hands it to a neighbor on insert or readout
// ----------------------------------------------------------------------------
module tkns_cell import tkns_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  entry_t    cand,
    input  entry_t    left_entry,
    input  logic      left_after,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      after,
    output logic      worse
);

    entry_t entry_reg;
    entry_t entry_next;

    // strictly farther than the candidate, so ties stay ahead of it
    assign worse = occupied && (entry_reg.dist_code > cand.dist_code);
    // candidate belongs at or before this slot
    assign after = worse || !occupied;
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift_out) begin
            entry_next = right_entry;
        end else if (ctl.insert) begin
            if (left_after) begin
                entry_next = left_entry;
            end else if (after) begin
                entry_next = cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
